[src/vclp_pkg.sv]
// Shared types, character codes and helpers for the velocity command line parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vclp_pkg;

  localparam int ValueWidth   = 32;
  localparam int MagWidth     = ValueWidth - 1;
  localparam int TimeoutWidth = 24;
  localparam int ElapsedWidth = 25;
  localparam int NumFields    = 3;
  localparam int AddrWidth    = 3;
  localparam int DataWidth    = 32;

  localparam logic [TimeoutWidth-1:0] TimeoutReset = 24'd500;
  localparam logic [MagWidth-1:0]     MagMax       = '1;

  // register index, taken from paddr[2]
  localparam logic RegTimeout = 1'b0;

  localparam logic [7:0] ChrV     = 8'h56;
  localparam logic [7:0] ChrStar  = 8'h2A;
  localparam logic [7:0] ChrComma = 8'h2C;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] Chr0     = 8'h30;
  localparam logic [7:0] Chr9     = 8'h39;
  localparam logic [7:0] ChrUA    = 8'h41;
  localparam logic [7:0] ChrUF    = 8'h46;
  localparam logic [7:0] ChrLA    = 8'h61;
  localparam logic [7:0] ChrLF    = 8'h66;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    PH_EXPECT_V,
    PH_FIELD,
    PH_AFTER_SIGN,
    PH_DIGITS,
    PH_HEX,
    PH_DONE,
    PH_BAD
  } phase_e;

  typedef logic [ValueWidth-1:0] vel_t;

  typedef struct packed {
    logic line_ok;
    logic line_bad;
  } line_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= Chr0) && (c <= Chr9);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if ((c >= Chr0) && (c <= Chr9)) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= ChrUA) && (c <= ChrUF)) || ((c >= ChrLA) && (c <= ChrLF))) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[src/vclp_cfg.sv]
// APB register file: holds the failsafe timeout.
// Depends on vclp_pkg.
`timescale 1ns / 1ps

module vclp_cfg import vclp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrWidth-1:0]    paddr,
  input  logic [DataWidth-1:0]    pwdata,
  output logic [DataWidth-1:0]    prdata,
  output logic                    pready,
  output logic [TimeoutWidth-1:0] timeout_o
);

  logic [TimeoutWidth-1:0] timeout_q, timeout_d;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    timeout_d = timeout_q;
    if (wr_en && (paddr[2] == RegTimeout)) begin
      timeout_d = pwdata[TimeoutWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign prdata    = (paddr[2] == RegTimeout) ? DataWidth'(timeout_q) : '0;
  assign timeout_o = timeout_q;

endmodule

[src/vclp_parser.sv]
// Byte-level sentence parser: framing, XOR checksum, signed integer fields.
// Depends on vclp_pkg.
`timescale 1ns / 1ps

module vclp_parser import vclp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      byte_en_i,
  input  logic [7:0] byte_i,
  input  logic      last_i,
  output line_res_t res_o,
  output vel_t      staged_o [NumFields]
);

  phase_e              phase_q, phase_d, phase_step;
  logic [7:0]          csum_q, csum_d;
  logic [7:0]          exp_q, exp_d;
  logic [1:0]          hex_cnt_q, hex_cnt_d;
  logic [MagWidth-1:0] acc_q, acc_d;
  logic                neg_q, neg_d;
  logic [1:0]          fidx_q, fidx_d;
  vel_t                staged_q [NumFields];

  logic                stage_we;
  vel_t                stage_val;
  logic [MagWidth+3:0] acc_x10;
  logic [4:0]          hex;
  logic [7:0]          exp_shift;

  assign stage_val = neg_q ? (vel_t'(0) - vel_t'({1'b0, acc_q})) : vel_t'({1'b0, acc_q});
  assign acc_x10   = (MagWidth+4)'({acc_q, 3'b000}) + (MagWidth+4)'({acc_q, 1'b0})
                   + (MagWidth+4)'(byte_i[3:0]);
  assign hex       = hex_decode(byte_i);
  assign exp_shift = {exp_q[3:0], hex[3:0]};

  always_comb begin
    phase_step = phase_q;
    csum_d     = csum_q;
    exp_d      = exp_q;
    hex_cnt_d  = hex_cnt_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    fidx_d     = fidx_q;
    stage_we   = 1'b0;
    if (byte_en_i) begin
      unique case (phase_q)
        PH_EXPECT_V: begin
          if (byte_i == ChrV) begin
            csum_d     = byte_i;
            fidx_d     = '0;
            acc_d      = '0;
            neg_d      = 1'b0;
            phase_step = PH_FIELD;
          end else begin
            phase_step = PH_BAD;
          end
        end
        PH_FIELD, PH_AFTER_SIGN: begin
          if (byte_i != ChrStar) csum_d = csum_q ^ byte_i;
          if ((phase_q == PH_FIELD) && (byte_i == ChrMinus)) begin
            neg_d      = 1'b1;
            phase_step = PH_AFTER_SIGN;
          end else if (is_digit(byte_i)) begin
            acc_d      = MagWidth'(byte_i[3:0]);
            phase_step = PH_DIGITS;
          end else begin
            phase_step = PH_BAD;
          end
        end
        PH_DIGITS: begin
          if (is_digit(byte_i)) begin
            csum_d = csum_q ^ byte_i;
            // saturate the magnitude
            acc_d  = (acc_x10 > (MagWidth+4)'(MagMax)) ? MagMax : acc_x10[MagWidth-1:0];
          end else if ((byte_i == ChrComma) && (fidx_q < 2'd2)) begin
            csum_d     = csum_q ^ byte_i;
            stage_we   = 1'b1;
            fidx_d     = fidx_q + 2'd1;
            acc_d      = '0;
            neg_d      = 1'b0;
            phase_step = PH_FIELD;
          end else if ((byte_i == ChrStar) && (fidx_q == 2'd2)) begin
            stage_we   = 1'b1;
            hex_cnt_d  = '0;
            exp_d      = '0;
            phase_step = PH_HEX;
          end else begin
            phase_step = PH_BAD;
          end
        end
        PH_HEX: begin
          if (!hex[4]) begin
            phase_step = PH_BAD;
          end else begin
            exp_d     = exp_shift;
            hex_cnt_d = hex_cnt_q + 2'd1;
            if (hex_cnt_q == 2'd1) begin
              phase_step = (exp_shift == csum_q) ? PH_DONE : PH_BAD;
            end
          end
        end
        default: ;
      endcase
    end

    phase_d = phase_step;
    if (byte_en_i && last_i) begin
      phase_d   = PH_EXPECT_V;
      csum_d    = '0;
      exp_d     = '0;
      hex_cnt_d = '0;
      fidx_d    = '0;
      acc_d     = '0;
      neg_d     = 1'b0;
    end

    res_o.line_ok  = byte_en_i && last_i && (phase_step == PH_DONE);
    res_o.line_bad = byte_en_i && last_i && (phase_step != PH_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_EXPECT_V;
      csum_q    <= '0;
      exp_q     <= '0;
      hex_cnt_q <= '0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      fidx_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      csum_q    <= csum_d;
      exp_q     <= exp_d;
      hex_cnt_q <= hex_cnt_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      fidx_q    <= fidx_d;
    end
  end

  // staging slots: written before they are ever copied, no reset
  always_ff @(posedge clk_i) begin
    if (stage_we) begin
      staged_q[fidx_q] <= stage_val;
    end
  end

  assign staged_o = staged_q;

endmodule

[src/velocity_command_line_parser_core.sv]
// Top level of the velocity command line parser with link failsafe.
// Depends on vclp_pkg, vclp_cfg and vclp_parser.
`timescale 1ns / 1ps

// Usage
//  Input stream (s_axis_*): one request per item. tuser selects a line byte (0)
//  or a time tick (1); tdata carries the byte; tlast flags the last byte of a line.
//  Output stream (m_axis_*): exactly one result per request, in order. tdata holds
//  x, y, z velocity (32 bit signed each, x lowest); tuser holds line_accepted,
//  line_rejected, link_live (lowest bit first).
//  A line "V<int>,<int>,<int>*HH" with a matching XOR checksum latches the three
//  velocities and restarts the failsafe tick counter; once that counter passes
//  the timeout register, or before any good line, the velocities read as zero.
//  APB port: register 0 (byte address 0) is the 24 bit failsafe timeout.
//  Timing: the result reaches the output register in the cycle after acceptance.
//  Throughput: one request per cycle unless stalled; the parser step, the tick
//  counter and the timeout compare all sit between request port and output register.
//  Stall: while the receiver holds tready low with a result pending, tready on
//  the input side drops; nothing is lost or repeated.
//  Reset: parser waits for a leading V, velocities zero, link dead, timeout 500.

module velocity_command_line_parser_core import vclp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] byte_value
  input  logic                    s_axis_tuser,   // [0] req_type
  input  logic                    s_axis_tlast,
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [3*ValueWidth-1:0] m_axis_tdata,   // [31:0] x, [63:32] y, [95:64] z
  output logic [2:0]              m_axis_tuser,   // [0] accepted, [1] rejected, [2] live
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrWidth-1:0]    paddr,
  input  logic [DataWidth-1:0]    pwdata,
  output logic [DataWidth-1:0]    prdata,
  output logic                    pready
);

  logic                    s_fire, m_fire, byte_en, tick_en;
  logic [TimeoutWidth-1:0] timeout;
  line_res_t               res;
  vel_t                    staged [NumFields];

  vel_t                    held_q [NumFields];
  vel_t                    held_d [NumFields];
  logic                    ever_q, ever_d;
  logic [ElapsedWidth-1:0] elapsed_q, elapsed_d;
  logic                    live;

  logic                    out_valid_q, out_valid_d;
  logic [3*ValueWidth-1:0] out_data_q, out_data_d;
  logic [2:0]              out_user_q, out_user_d;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign m_fire  = m_axis_tvalid && m_axis_tready;
  assign byte_en = s_fire && (s_axis_tuser == REQ_BYTE);
  assign tick_en = s_fire && (s_axis_tuser == REQ_TICK);

  // output register frees up in the same cycle it is taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  vclp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .timeout_o (timeout)
  );

  vclp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .byte_i    (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .res_o     (res),
    .staged_o  (staged)
  );

  always_comb begin
    elapsed_d = elapsed_q;
    ever_d    = ever_q | res.line_ok;
    if (tick_en && (elapsed_q != '1)) begin
      // counter parks at all ones, above any timeout
      elapsed_d = elapsed_q + ElapsedWidth'(1);
    end else if (res.line_ok) begin
      elapsed_d = '0;
    end
    for (int i = 0; i < NumFields; i++) begin
      held_d[i] = res.line_ok ? staged[i] : held_q[i];
    end
    live = ever_d && (elapsed_d <= ElapsedWidth'(timeout));

    out_data_d = out_data_q;
    out_user_d = out_user_q;
    if (s_fire) begin
      for (int i = 0; i < NumFields; i++) begin
        out_data_d[i*ValueWidth +: ValueWidth] = live ? held_d[i] : '0;
      end
      out_user_d = {live, res.line_bad, res.line_ok};
    end

    out_valid_d = out_valid_q;
    if (s_fire) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ever_q      <= 1'b0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumFields; i++) begin
        held_q[i] <= '0;
      end
    end else begin
      ever_q      <= ever_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // a line cannot be both accepted and rejected
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("accepted and rejected both set");

  // dead link reports zero velocity
  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata == '0))
    else $error("nonzero velocity while link is dead");

  // a good line restarts the failsafe counter and marks the link as seen
  a_line_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.line_ok |=> (elapsed_q == '0) && ever_q)
    else $error("good line did not restart failsafe counter");

  // an empty output register never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

[test/tb.sv]
// Testbench for velocity_command_line_parser_core: directed and random command lines,
// time ticks and timeout settings, checked against a cycle-free model of the parser.
// Depends on vclp_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import vclp_pkg::*;

  // APB byte addresses: register 0 is the timeout, address 4 maps to no register
  localparam logic [AddrWidth-1:0] TimeoutAddr = 3'd0;
  localparam logic [AddrWidth-1:0] SpareAddr   = 3'd4;
  // cycles with no request, result or APB access before the run is declared hung
  localparam int QuietLimit = 5000;
  localparam int PhaseItems = 410;

  // one result as it leaves the block: {tuser, tdata}
  typedef struct packed {
    logic live;
    logic rejected;
    logic accepted;
    vel_t z_vel;
    vel_t y_vel;
    vel_t x_vel;
  } velocity_report_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata  = '0;   // [7:0] byte_value
  logic                    s_axis_tuser  = REQ_BYTE;  // [0] req_type
  logic                    s_axis_tlast  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [3*ValueWidth-1:0] m_axis_tdata;   // [31:0] x, [63:32] y, [95:64] z
  logic [2:0]              m_axis_tuser;   // [0] accepted, [1] rejected, [2] live
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [AddrWidth-1:0]    paddr         = '0;
  logic [DataWidth-1:0]    pwdata        = '0;
  logic [DataWidth-1:0]    prdata;
  logic                    pready;

  velocity_command_line_parser_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model: its own copy of the line state, the latched command and the
  // failsafe counter. Values here are the reset values.
  // ---------------------------------------------------------------------------
  phase_e                  cmd_phase    = PH_EXPECT_V;
  logic [7:0]              line_xor     = '0;   // XOR of bytes before the first '*'
  logic [7:0]              sent_sum     = '0;   // hex pair as received
  logic [1:0]              hex_seen     = '0;
  logic [31:0]             digit_mag    = '0;
  logic                    digit_neg    = 1'b0;
  logic [1:0]              field_idx    = '0;
  vel_t                    staged_vel [NumFields] = '{default: '0};
  vel_t                    held_vel   [NumFields] = '{default: '0};
  logic                    link_ever    = 1'b0;
  logic [ElapsedWidth-1:0] tick_count   = '0;
  logic [TimeoutWidth-1:0] timeout_ticks = TimeoutReset;

  velocity_report_t expected_reports [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int lines_ok       = 0;
  int lines_bad      = 0;
  int live_reports   = 0;

  function automatic void report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want)
      report_error($sformatf("%s expected %0d (0x%h), got %0d (0x%h)",
                             name, $signed(want), want, $signed(got), got));
  endfunction

  function automatic void restart_command_parser();
    cmd_phase = PH_EXPECT_V;
    line_xor  = '0;
    sent_sum  = '0;
    hex_seen  = '0;
    field_idx = '0;
    digit_mag = '0;
    digit_neg = 1'b0;
  endfunction

  function automatic void stage_field_value();
    staged_vel[field_idx] = digit_neg ? (32'd0 - digit_mag) : digit_mag;
  endfunction

  // -1 when the byte is not a hex digit
  function automatic int hex_digit_value(input logic [7:0] ch);
    if (ch >= Chr0 && ch <= Chr9) return int'(ch - Chr0);
    if (ch >= ChrUA && ch <= ChrUF) return int'(ch - ChrUA) + 10;
    if (ch >= ChrLA && ch <= ChrLF) return int'(ch - ChrLA) + 10;
    return -1;
  endfunction

  function automatic void parse_line_byte(input logic [7:0] ch);
    int          nib;
    logic        dec;
    logic [63:0] grown;
    nib   = hex_digit_value(ch);
    dec   = (ch >= Chr0) && (ch <= Chr9);
    grown = 64'(digit_mag) * 64'd10 + 64'(ch) - 64'(Chr0);
    case (cmd_phase)
      PH_EXPECT_V: begin
        if (ch == ChrV) begin
          line_xor  = ch;
          field_idx = '0;
          digit_mag = '0;
          digit_neg = 1'b0;
          cmd_phase = PH_FIELD;
        end else begin
          cmd_phase = PH_BAD;
        end
      end
      PH_FIELD, PH_AFTER_SIGN: begin
        if (ch != ChrStar) line_xor ^= ch;
        // only one sign per integer
        if (cmd_phase == PH_FIELD && ch == ChrMinus) begin
          digit_neg = 1'b1;
          cmd_phase = PH_AFTER_SIGN;
        end else if (dec) begin
          digit_mag = 32'(ch - Chr0);
          cmd_phase = PH_DIGITS;
        end else begin
          cmd_phase = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (dec) begin
          line_xor ^= ch;
          // magnitude saturates instead of wrapping
          digit_mag = (grown > 64'(MagMax)) ? 32'(MagMax) : grown[31:0];
        end else if (ch == ChrComma && field_idx < 2'd2) begin
          line_xor ^= ch;
          stage_field_value();
          field_idx = field_idx + 2'd1;
          digit_mag = '0;
          digit_neg = 1'b0;
          cmd_phase = PH_FIELD;
        end else if (ch == ChrStar && field_idx == 2'd2) begin
          stage_field_value();
          hex_seen  = '0;
          sent_sum  = '0;
          cmd_phase = PH_HEX;
        end else begin
          cmd_phase = PH_BAD;
        end
      end
      PH_HEX: begin
        if (nib < 0) begin
          cmd_phase = PH_BAD;
        end else begin
          sent_sum = {sent_sum[3:0], 4'(nib)};
          hex_seen = hex_seen + 2'd1;
          if (hex_seen == 2'd2) cmd_phase = (sent_sum == line_xor) ? PH_DONE : PH_BAD;
        end
      end
      default: ;  // done or bad: rest of the line is ignored
    endcase
  endfunction

  // result of one request, advancing the model state
  function automatic velocity_report_t predict_report(input req_e kind, input logic [7:0] ch,
                                                      input logic last);
    velocity_report_t rep;
    rep = '0;
    if (kind == REQ_TICK) begin
      if (tick_count != '1) tick_count = tick_count + 1'b1;
    end else begin
      parse_line_byte(ch);
      if (last) begin
        if (cmd_phase == PH_DONE) begin
          rep.accepted = 1'b1;
          held_vel     = staged_vel;
          link_ever    = 1'b1;
          tick_count   = '0;
        end else begin
          rep.rejected = 1'b1;
        end
        restart_command_parser();
      end
    end
    rep.live = link_ever && (tick_count <= {1'b0, timeout_ticks});
    if (rep.live) begin
      rep.x_vel = held_vel[0];
      rep.y_vel = held_vel[1];
      rep.z_vel = held_vel[2];
    end
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Predict on every accepted request, check every accepted result. Prediction
  // goes first so a result in the same cycle would still find its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : report_checker
    velocity_report_t want;
    velocity_report_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_reports.push_back(predict_report(req_e'(s_axis_tuser), s_axis_tdata,
                                                  s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        got = velocity_report_t'({m_axis_tuser, m_axis_tdata});
        if (expected_reports.size() == 0) begin
          report_error("result arrived with no request pending");
        end else begin
          want = expected_reports.pop_front();
          check_field("x velocity", want.x_vel, got.x_vel);
          check_field("y velocity", want.y_vel, got.y_vel);
          check_field("z velocity", want.z_vel, got.z_vel);
          check_field("line_accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("line_rejected", 32'(want.rejected), 32'(got.rejected));
          check_field("link_live", 32'(want.live), 32'(got.live));
          if (want.accepted) lines_ok++;
          if (want.rejected) lines_bad++;
          if (want.live) live_reports++;
        end
      end
    end
  end

  // Receiver: stall pattern is redrawn whenever stall_clock wraps; mode 0 never stalls.
  logic [6:0] stall_clock = '0;
  logic [1:0] stall_mode  = '0;

  always @(negedge clk_i) begin
    stall_clock <= stall_clock + 7'd1;
    if (stall_clock == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_clock[3:0] < 4'd11);  // periodic stall
    endcase
  end

  // Hang detection: any request, result or APB access restarts the count.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               QuietLimit, expected_reports.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. All drive tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // one request, sent in bursts of random length with random gaps between them
  task automatic send_request(input req_e kind, input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // byte and last flag of a tick carry random junk: the block must ignore them
  task automatic send_tick();
    send_request(REQ_TICK, 8'($urandom), 1'($urandom));
  endtask

  logic [7:0] line_buf [$];

  // sends line_buf with tlast on its final byte; optionally a tick after byte tick_after
  task automatic send_line(input int tick_after);
    foreach (line_buf[i]) begin
      send_request(REQ_BYTE, line_buf[i], i == line_buf.size() - 1);
      if (i == tick_after) send_tick();
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one APB write, or a read checked against the model's timeout
  task automatic apb_transfer(input logic write, input logic [AddrWidth-1:0] addr,
                              input logic [DataWidth-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    if (write && addr == TimeoutAddr) timeout_ticks = data[TimeoutWidth-1:0];
    if (!write) check_field("timeout readback", 32'(timeout_ticks), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Line building
  // ---------------------------------------------------------------------------
  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // optional sign, usually a few digits, sometimes enough to saturate
  function automatic void append_random_number();
    int ndig;
    if ($urandom_range(0, 2) == 0) line_buf.push_back(ChrMinus);
    case ($urandom_range(0, 15))
      0:       append_text("2147483647");
      1:       append_text("2147483648");
      2, 3:    ndig = $urandom_range(9, 13);
      default: ndig = $urandom_range(1, 4);
    endcase
    repeat (ndig) line_buf.push_back(Chr0 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return Chr0 + 8'(nib);
    return (($urandom_range(0, 1) != 0) ? ChrUA : ChrLA) + 8'(nib) - 8'd10;
  endfunction

  // '*' and the hex pair over everything already in line_buf
  function automatic void append_checksum(input logic corrupt);
    logic [7:0] sum;
    sum = '0;
    foreach (line_buf[i]) sum ^= line_buf[i];
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    line_buf.push_back(ChrStar);
    line_buf.push_back(hex_char(sum[7:4]));
    line_buf.push_back(hex_char(sum[3:0]));
  endfunction

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 5))
      0:       return ChrStar;
      1:       return ChrComma;
      2:       return ChrMinus;
      3:       return 8'h00;
      4:       return ChrV;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed lines with random content; some noise and broken lines
  task automatic send_random_line();
    int pos;
    int tick_at;
    line_buf.delete();
    append_text("V");
    append_random_number();
    line_buf.push_back(ChrComma);
    append_random_number();
    line_buf.push_back(ChrComma);
    append_random_number();
    append_checksum($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) line_buf.push_back(odd_byte());
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        line_buf.delete();
        if ($urandom_range(0, 1) != 0) line_buf.push_back(ChrV);
        repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom));
      end
      3, 4, 5: begin
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: line_buf[pos] = odd_byte();
          1: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());  // ends early
          2: line_buf.insert(pos, odd_byte());
          default: if (line_buf.size() > 1) line_buf.delete(pos);
        endcase
      end
      default: ;
    endcase
    tick_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, line_buf.size() - 1) : -1;
    send_line(tick_at);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset value reads back; a write to an address with no register changes nothing
  task automatic test_register_access();
    apb_transfer(1'b0, TimeoutAddr, '0);
    apb_transfer(1'b1, SpareAddr, 32'hFFFF_FFFF);
    apb_transfer(1'b0, TimeoutAddr, '0);
  endtask

  // before any good line the link is dead; tick byte and last flag are ignored
  task automatic test_tick_before_any_line();
    send_request(REQ_TICK, 8'hFF, 1'b1);
    send_request(REQ_TICK, 8'h00, 1'b0);
  endtask

  // wrong leading byte, line ending right after V, '*' in the first field
  task automatic test_line_errors();
    line_buf.delete();
    append_text("X");
    send_line(-1);
    line_buf.delete();
    append_text("V");
    send_line(-1);
    line_buf.delete();
    append_text("V1*");
    send_line(-1);
  endtask

  // x overflows and saturates, then a tick inside the reset timeout keeps it live
  task automatic test_digit_saturation();
    line_buf.delete();
    append_text("V4294967296,-7,0");
    append_checksum(1'b0);
    send_line(-1);
    send_tick();
  endtask

  // new timeout, then random lines separated by up to tick_span ticks
  task automatic test_failsafe_random(input logic [DataWidth-1:0] timeout_word,
                                      input int tick_span);
    int stop_at;
    wait_drained();
    apb_transfer(1'b1, TimeoutAddr, timeout_word);
    apb_transfer(1'b0, TimeoutAddr, '0);
    stop_at = items_sent + PhaseItems;
    while (items_sent < stop_at) begin
      repeat ($urandom_range(0, tick_span)) send_tick();
      send_random_line();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_register_access();
    test_tick_before_any_line();
    test_line_errors();
    test_digit_saturation();
    // zero timeout: live only until the first tick after a good line
    test_failsafe_random(32'd0, 2);
    test_failsafe_random(32'd7, 14);
    // upper bits of the write are dropped: largest timeout, never expires here
    test_failsafe_random(32'hFFFF_FFFF, 3);
    test_failsafe_random(32'($urandom_range(1, 40)), 50);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expected_reports.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_reports.size()));

    $display("covered %0d requests: %0d good lines, %0d rejected lines, %0d live results",
             items_sent, lines_ok, lines_bad, live_reports);
    $display("timeouts 500, 0, 7, max and random; %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
